### design/damped_wave_grid_step_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wave grid core
// Concurrent checks, clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DAMPED_WAVE_GRID_STEP_CORE_DEFINES_SVH
`define DAMPED_WAVE_GRID_STEP_CORE_DEFINES_SVH

// same-cycle implication
`define DWGS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DWGS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/dwgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwgs_pkg
// Shared widths, codes, control struct and saturation for the wave grid core.
// ----------------------------------------------------------------------------
package dwgs_pkg;

	localparam int DEF_GRID_ROWS = 64;
	localparam int DEF_GRID_COLS = 64;

	localparam int OP_W   = 2;
	localparam int RC_W   = 6;
	localparam int VAL_W  = 32;
	localparam int GAIN_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int LAP_W  = 35;   // sum of four neighbours minus 4h
	localparam int DIF_W  = 33;   // h - p
	localparam int MUL_A_W = GAIN_W + 1;
	localparam int PROD_W = MUL_A_W + LAP_W;
	localparam int FRAC_W = 16;
	localparam int ACC_W  = 40;

	localparam logic [OP_W-1:0] OP_WR_CUR  = 2'd0;
	localparam logic [OP_W-1:0] OP_WR_PREV = 2'd1;
	localparam logic [OP_W-1:0] OP_RD_CUR  = 2'd2;
	localparam logic [OP_W-1:0] OP_STEP    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_LAP_GAIN  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMP_GAIN = 1'b1;

	localparam logic [GAIN_W-1:0] LAP_GAIN_RST  = 16'd164;
	localparam logic [GAIN_W-1:0] DAMP_GAIN_RST = 16'd328;

	// shared adder operations
	localparam logic [2:0] ALU_HOLD = 3'd0;
	localparam logic [2:0] ALU_M4H  = 3'd1;
	localparam logic [2:0] ALU_NB   = 3'd2;
	localparam logic [2:0] ALU_2HP  = 3'd3;
	localparam logic [2:0] ALU_ADDP = 3'd4;
	localparam logic [2:0] ALU_SUBP = 3'd5;

	localparam logic MUL_LAP  = 1'b0;
	localparam logic MUL_DAMP = 1'b1;

	typedef struct packed {
		logic       cap;
		logic       acc_en;
		logic [2:0] alu_op;
		logic       mul_en;
		logic       mul_sel;
	} dwgs_ctl_t;

	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}));
		lo = ACC_W'(signed'({1'b1, {(VAL_W-1){1'b0}}}));
		if (x > hi)
			return hi[VAL_W-1:0];
		else if (x < lo)
			return lo[VAL_W-1:0];
		else
			return x[VAL_W-1:0];
	endfunction

endpackage

### design/dwgs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwgs_in_if
// Request channel: opcode, cell index and write value.
// ----------------------------------------------------------------------------
interface dwgs_in_if;
	logic                              valid;
	logic                              ready;
	logic [dwgs_pkg::OP_W-1:0]         opcode;
	logic [dwgs_pkg::RC_W-1:0]         row;
	logic [dwgs_pkg::RC_W-1:0]         col;
	logic signed [dwgs_pkg::VAL_W-1:0] write_value;

	modport source(output valid, opcode, row, col, write_value, input ready);
	modport sink(input valid, opcode, row, col, write_value, output ready);
endinterface

### design/dwgs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwgs_out_if
// Result channel: height read back or step completion.
// ----------------------------------------------------------------------------
interface dwgs_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [dwgs_pkg::VAL_W-1:0] height_value;
	logic                              step_done;

	modport source(output valid, height_value, step_done, input ready);
	modport sink(input valid, height_value, step_done, output ready);
endinterface

### design/dwgs_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwgs_bank
// One height bank: single write port, single registered read port.
// ----------------------------------------------------------------------------
module dwgs_bank #(
	parameter int DEPTH = dwgs_pkg::DEF_GRID_ROWS * dwgs_pkg::DEF_GRID_COLS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [dwgs_pkg::VAL_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [dwgs_pkg::VAL_W-1:0] rdata
);
	import dwgs_pkg::*;

	logic [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### design/dwgs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwgs_datapath
// Shared adder and multiplier that build one new cell height over cycles.
// ----------------------------------------------------------------------------
module dwgs_datapath (
	input  logic                              clk,
	input  dwgs_pkg::dwgs_ctl_t               ctl,
	input  logic [dwgs_pkg::GAIN_W-1:0]       lap_gain,
	input  logic [dwgs_pkg::GAIN_W-1:0]       damp_gain,
	input  logic signed [dwgs_pkg::VAL_W-1:0] rd_cur,
	input  logic signed [dwgs_pkg::VAL_W-1:0] rd_prv,
	output logic signed [dwgs_pkg::VAL_W-1:0] nxt_val
);
	import dwgs_pkg::*;

	logic signed [VAL_W-1:0]        h_q;
	logic signed [VAL_W-1:0]        p_q;
	logic signed [DIF_W-1:0]        d_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic signed [PROD_W-FRAC_W-1:0] prod_sh;
	logic signed [ACC_W-1:0]        add_a;
	logic signed [ACC_W-1:0]        add_b;
	logic                           add_sub;
	logic signed [ACC_W-1:0]        add_sum;
	logic signed [MUL_A_W-1:0]      mul_a;
	logic signed [LAP_W-1:0]        mul_b;

	// floor of the product over 2^16
	assign prod_sh = prod_q[PROD_W-1:FRAC_W];

	always_comb begin
		add_a   = acc_q;
		add_b   = '0;
		add_sub = 1'b0;
		unique case (ctl.alu_op)
			ALU_M4H: begin
				add_a   = '0;
				add_b   = ACC_W'(rd_cur) <<< 2;
				add_sub = 1'b1;
			end
			ALU_NB: begin
				add_b = ACC_W'(rd_cur);
			end
			ALU_2HP: begin
				add_a   = ACC_W'(h_q) <<< 1;
				add_b   = ACC_W'(p_q);
				add_sub = 1'b1;
			end
			ALU_ADDP: begin
				add_b = ACC_W'(prod_sh);
			end
			ALU_SUBP: begin
				add_b   = ACC_W'(prod_sh);
				add_sub = 1'b1;
			end
			default: begin
				add_b = '0;
			end
		endcase
		add_sum = add_a + (add_b ^ {ACC_W{add_sub}}) + ACC_W'(add_sub);
	end

	assign mul_a = signed'({1'b0, (ctl.mul_sel == MUL_DAMP) ? damp_gain : lap_gain});
	assign mul_b = (ctl.mul_sel == MUL_DAMP) ? LAP_W'(d_q) : acc_q[LAP_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			h_q <= rd_cur;
			p_q <= rd_prv;
			d_q <= DIF_W'(rd_cur) - DIF_W'(rd_prv);
		end
		if (ctl.acc_en)
			acc_q <= add_sum;
		if (ctl.mul_en)
			prod_q <= mul_a * mul_b;
	end

	assign nxt_val = sat_val(acc_q);

endmodule

### design/damped_wave_grid_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_wave_grid_step_core
// Damped wave equation on a toroidal Q16.16 height grid.
// ----------------------------------------------------------------------------
// After reset the core runs a clearing pass over every cell that zeroes the
// current and previous banks; no request is taken until it ends (gain writes
// are taken throughout). Requests are handled one at a time. The row and col
// of a request are first wrapped onto a grid smaller than 64 by repeated
// subtraction. A cell write then writes its bank; a read captures the bank's
// registered output for the output register. An advance request sweeps every
// cell in turn through its capture, neighbour, multiply, subtract and write
// phases on one shared adder and one multiplier, fed by a single read port on
// the current bank. Three banks rotate roles: current, previous and next, so
// no copy is needed at the end of a step. A finished result sits in an output
// register until taken.
// ----------------------------------------------------------------------------
module damped_wave_grid_step_core #(
	parameter int GRID_ROWS = dwgs_pkg::DEF_GRID_ROWS,
	parameter int GRID_COLS = dwgs_pkg::DEF_GRID_COLS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	dwgs_in_if.sink                        in_ch,
	dwgs_out_if.source                     out_ch,
	input  logic                           cfg_we,
	input  logic [dwgs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dwgs_pkg::GAIN_W-1:0]    cfg_wdata
);
	import dwgs_pkg::*;

	`include "damped_wave_grid_step_core_defines.svh"

	localparam int CELLS = GRID_ROWS * GRID_COLS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(GRID_ROWS);
	localparam int CW    = $clog2(GRID_COLS);
	localparam int PH_W  = 4;

	// per-cell phases of the sweep
	localparam logic [PH_W-1:0] PH_CAP   = 4'd1;
	localparam logic [PH_W-1:0] PH_DN    = 4'd2;
	localparam logic [PH_W-1:0] PH_RT    = 4'd3;
	localparam logic [PH_W-1:0] PH_LT    = 4'd4;
	localparam logic [PH_W-1:0] PH_NB_LAST = 4'd5;
	localparam logic [PH_W-1:0] PH_MLAP  = 4'd6;
	localparam logic [PH_W-1:0] PH_MDMP  = 4'd7;
	localparam logic [PH_W-1:0] PH_SUB   = 4'd8;
	localparam logic [PH_W-1:0] PH_WR    = 4'd9;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RED  = 3'd2;
	localparam logic [2:0] S_MEM  = 3'd3;
	localparam logic [2:0] S_RDW  = 3'd4;
	localparam logic [2:0] S_STEP = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]        state_q;
	logic [AW-1:0]     clr_q;
	logic [OP_W-1:0]   op_q;
	logic [RC_W-1:0]   r_q;
	logic [RC_W-1:0]   c_q;
	logic [VAL_W-1:0]  wv_q;
	logic [RW-1:0]     i_q;
	logic [CW-1:0]     j_q;
	logic [PH_W-1:0]   ph_q;
	logic [1:0]        rot_q;
	logic [GAIN_W-1:0] lap_gain_q;
	logic [GAIN_W-1:0] damp_gain_q;
	logic [VAL_W-1:0]  res_val_q;
	logic              res_step_q;
	logic              out_v_q;
	logic [VAL_W-1:0]  out_h_q;
	logic              out_s_q;

	logic [1:0]        cur_b;
	logic [1:0]        prv_b;
	logic [1:0]        nxt_b;
	logic [RW-1:0]     row_sel;
	logic [CW-1:0]     col_sel;
	logic [AW-1:0]     sweep_addr;
	logic [AW-1:0]     cen_addr;
	logic [AW-1:0]     req_addr;
	logic [AW-1:0]     cur_ra;
	logic              wr_en;
	logic              clr_en;
	logic [1:0]        wr_b;
	logic [AW-1:0]     wr_addr;
	logic [VAL_W-1:0]  wr_data;
	logic [2:0]        bank_we;
	logic [VAL_W-1:0]  bank_rd [3];
	logic signed [VAL_W-1:0] rd_cur;
	logic signed [VAL_W-1:0] rd_prv;
	logic signed [VAL_W-1:0] nxt_val;
	logic              slot_free;
	logic              row_ok;
	logic              col_ok;
	logic              last_cell;
	dwgs_ctl_t         ctl;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
		return AW'(r) * AW'(GRID_COLS) + AW'(c);
	endfunction

	// bank roles follow the rotation
	assign cur_b = rot_q;
	assign prv_b = (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;
	assign nxt_b = (rot_q == 2'd0) ? 2'd2 : rot_q - 2'd1;

	assign slot_free = !out_v_q || out_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);

	assign row_ok = (int'(r_q) < GRID_ROWS);
	assign col_ok = (int'(c_q) < GRID_COLS);
	assign last_cell = (i_q == RW'(GRID_ROWS - 1)) && (j_q == CW'(GRID_COLS - 1));

	// neighbour selection with wraparound
	always_comb begin
		row_sel = i_q;
		col_sel = j_q;
		priority if (state_q == S_STEP && ph_q == PH_CAP)
			row_sel = (i_q == RW'(GRID_ROWS - 1)) ? '0 : i_q + RW'(1);
		else if (state_q == S_STEP && ph_q == PH_DN)
			row_sel = (i_q == '0) ? RW'(GRID_ROWS - 1) : i_q - RW'(1);
		else if (state_q == S_STEP && ph_q == PH_RT)
			col_sel = (j_q == CW'(GRID_COLS - 1)) ? '0 : j_q + CW'(1);
		else if (state_q == S_STEP && ph_q == PH_LT)
			col_sel = (j_q == '0) ? CW'(GRID_COLS - 1) : j_q - CW'(1);
		else
			col_sel = j_q;
	end

	assign sweep_addr = cell_addr(row_sel, col_sel);
	assign cen_addr   = cell_addr(i_q, j_q);
	assign req_addr   = cell_addr(RW'(r_q), CW'(c_q));
	assign cur_ra     = (state_q == S_STEP) ? sweep_addr : req_addr;

	// single write path into the banks
	always_comb begin
		clr_en  = 1'b0;
		wr_en   = 1'b0;
		wr_b    = cur_b;
		wr_addr = req_addr;
		wr_data = wv_q;
		unique case (state_q)
			S_CLR: begin
				clr_en  = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_MEM: begin
				wr_en = (op_q == OP_WR_CUR) || (op_q == OP_WR_PREV);
				wr_b  = (op_q == OP_WR_PREV) ? prv_b : cur_b;
			end
			S_STEP: begin
				wr_en   = (ph_q == PH_WR);
				wr_b    = nxt_b;
				wr_addr = cen_addr;
				wr_data = nxt_val;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	for (genvar b = 0; b < 3; b++) begin : g_bank
		assign bank_we[b] = (clr_en && (2'(b) == cur_b || 2'(b) == prv_b))
			|| (wr_en && 2'(b) == wr_b);

		dwgs_bank #(
			.DEPTH (CELLS),
			.AW    (AW)
		) u_bank (
			.clk   (clk),
			.we    (bank_we[b]),
			.waddr (wr_addr),
			.wdata (wr_data),
			.raddr ((2'(b) == prv_b) ? cen_addr : cur_ra),
			.rdata (bank_rd[b])
		);
	end

	assign rd_cur = bank_rd[cur_b];
	assign rd_prv = bank_rd[prv_b];

	// datapath control for each phase of a cell
	always_comb begin
		ctl = '{cap: 1'b0, acc_en: 1'b0, alu_op: ALU_HOLD, mul_en: 1'b0, mul_sel: MUL_LAP};
		if (state_q == S_STEP) begin
			if (ph_q == PH_CAP) begin
				ctl.cap    = 1'b1;
				ctl.acc_en = 1'b1;
				ctl.alu_op = ALU_M4H;
			end else if (ph_q >= PH_DN && ph_q <= PH_NB_LAST) begin
				ctl.acc_en = 1'b1;
				ctl.alu_op = ALU_NB;
			end else if (ph_q == PH_MLAP) begin
				ctl.mul_en = 1'b1;
				ctl.acc_en = 1'b1;
				ctl.alu_op = ALU_2HP;
			end else if (ph_q == PH_MDMP) begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MUL_DAMP;
				ctl.acc_en  = 1'b1;
				ctl.alu_op  = ALU_ADDP;
			end else if (ph_q == PH_SUB) begin
				ctl.acc_en = 1'b1;
				ctl.alu_op = ALU_SUBP;
			end
		end
	end

	dwgs_datapath u_dp (
		.clk       (clk),
		.ctl       (ctl),
		.lap_gain  (lap_gain_q),
		.damp_gain (damp_gain_q),
		.rd_cur    (rd_cur),
		.rd_prv    (rd_prv),
		.nxt_val   (nxt_val)
	);

	// gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lap_gain_q  <= LAP_GAIN_RST;
			damp_gain_q <= DAMP_GAIN_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_LAP_GAIN)
				lap_gain_q <= cfg_wdata;
			else
				damp_gain_q <= cfg_wdata;
		end
	end

	// request payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_q <= in_ch.opcode;
			r_q  <= in_ch.row;
			c_q  <= in_ch.col;
			wv_q <= in_ch.write_value;
		end else if (state_q == S_RED) begin
			if (!row_ok)
				r_q <= r_q - RC_W'(GRID_ROWS);
			if (!col_ok)
				c_q <= c_q - RC_W'(GRID_COLS);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			i_q        <= '0;
			j_q        <= '0;
			ph_q       <= '0;
			rot_q      <= '0;
			res_val_q  <= '0;
			res_step_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_ch.valid) begin
						i_q  <= '0;
						j_q  <= '0;
						ph_q <= '0;
						state_q <= (in_ch.opcode == OP_STEP) ? S_STEP : S_RED;
					end
				end
				S_RED: begin
					if (row_ok && col_ok)
						state_q <= S_MEM;
				end
				S_MEM: begin
					state_q <= (op_q == OP_RD_CUR) ? S_RDW : S_IDLE;
				end
				S_RDW: begin
					res_val_q  <= rd_cur;
					res_step_q <= 1'b0;
					state_q    <= S_DONE;
				end
				S_STEP: begin
					if (ph_q == PH_WR) begin
						ph_q <= '0;
						if (last_cell) begin
							rot_q      <= nxt_b;
							res_val_q  <= '0;
							res_step_q <= 1'b1;
							state_q    <= S_DONE;
						end else if (j_q == CW'(GRID_COLS - 1)) begin
							j_q <= '0;
							i_q <= i_q + RW'(1);
						end else begin
							j_q <= j_q + CW'(1);
						end
					end else begin
						ph_q <= ph_q + PH_W'(1);
					end
				end
				S_DONE: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == S_DONE && slot_free) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && slot_free) begin
			out_h_q <= res_val_q;
			out_s_q <= res_step_q;
		end
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.height_value = out_h_q;
	assign out_ch.step_done    = out_s_q;

	// checks
	`DWGS_ASSERT_IMP(a_rot_range, 1'b1, rot_q != 2'd3, "bank rotation out of range")
	`DWGS_ASSERT_IMP(a_one_bank_we, state_q != S_CLR, $countones(bank_we) <= 1, "two banks written at once")
	`DWGS_ASSERT_NXT(a_result_out, state_q == S_DONE && slot_free, out_ch.valid, "result not presented")

endmodule
